// ----- src/omw_pkg.sv -----
// Shared types and constants for the 1-Wire bus master.
package omw_pkg;

  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_RESET = 3'd1,
    REQ_LONG  = 3'd2,
    REQ_WRITE = 3'd3,
    REQ_READ  = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    REG_RESET_LOW    = 3'd0,
    REG_RESET_REL    = 3'd1,
    REG_LONG_LOW     = 3'd2,
    REG_LONG_REL     = 3'd3,
    REG_W0_LOW       = 3'd4,
    REG_W1_LOW       = 3'd5,
    REG_READ_LOW     = 3'd6,
    REG_READ_SAMPLE  = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_CMD,
    KIND_NOP
  } kind_t;

  localparam int NumRegs = 8;
  localparam int TimeW   = 10;

  typedef logic [TimeW-1:0] us_t;

  localparam us_t W0ReleaseUs = 10'd15;
  localparam us_t W1ReleaseUs = 10'd60;
  localparam us_t ReadTailUs  = 10'd45;

  localparam us_t RegResetVals [NumRegs] = '{
    10'd60, 10'd50, 10'd720, 10'd10, 10'd60, 10'd5, 10'd2, 10'd15
  };

  typedef struct packed {
    kind_t       kind;
    req_t        cmd;
    logic [7:0]  data_byte;
    logic        line_level;
  } entry_t;

  function automatic us_t at_least_one(us_t v);
    return (v == '0) ? us_t'(1) : v;
  endfunction

endpackage

// ----- src/omw_if.sv -----
// Channel interfaces: request, result and configuration write.
interface omw_req_if import omw_pkg::*;;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] data_byte;
  logic       line_level;

  modport source (output valid, req_type, data_byte, line_level, input ready);
  modport sink   (input valid, req_type, data_byte, line_level, output ready);
endinterface

interface omw_res_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       cmd_error;

  modport source (output valid, drive_low, busy_res, done_res, read_data, cmd_error,
                  input ready);
  modport sink   (input valid, drive_low, busy_res, done_res, read_data, cmd_error,
                  output ready);
endinterface

interface omw_cfg_if import omw_pkg::*;;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [9:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/omw_front.sv -----
// Front end: accept request transfers, classify them and queue them.
module omw_front import omw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  omw_req_if.sink     req_ch,
  output entry_t      head,
  output logic        head_valid,
  input  logic        pop
);

  entry_t      queue [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  entry_t      entry_in;

  assign req_ch.ready = (count != 2'd2);
  assign push         = req_ch.valid && req_ch.ready;
  assign head         = queue[rd_ptr];
  assign head_valid   = (count != 2'd0);

  always_comb begin
    entry_in.cmd        = req_t'(req_ch.req_type);
    entry_in.data_byte  = req_ch.data_byte;
    entry_in.line_level = req_ch.line_level;
    case (req_ch.req_type) inside
      REQ_TICK:                 entry_in.kind = KIND_TICK;
      [REQ_RESET:REQ_READ]:     entry_in.kind = KIND_CMD;
      default:                  entry_in.kind = KIND_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
      push && !pop |=> count == $past(count) + 2'd1)
    else $error("queue count did not advance on push");
`endif

endmodule

// ----- src/omw_back.sv -----
// Back end: timing registers, bit-slot sequencer and result register.
module omw_back import omw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  omw_cfg_if.sink     cfg_ch,
  omw_res_if.source   res_ch,
  input  entry_t      head,
  input  logic        head_valid,
  output logic        pop
);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_LOW     = 3'd1,
    PH_RELEASE = 3'd2,
    PH_GAP     = 3'd3,
    PH_TAIL    = 3'd4
  } phase_t;

  us_t        regs [NumRegs];
  phase_t     phase, phase_next;
  req_t       active_cmd, active_cmd_next;
  us_t        timer, timer_next;
  logic [2:0] bit_idx, bit_idx_next;
  logic [7:0] shift, shift_next;

  logic       drive, done, err;
  logic [7:0] rdata;
  us_t        tdec, low_len, slot_len;
  logic       start;
  logic       start_bit;

  assign cfg_ch.ready = 1'b1;
  assign pop = head_valid && (!res_ch.valid || res_ch.ready);

  always_comb begin
    phase_next      = phase;
    active_cmd_next = active_cmd;
    timer_next      = timer;
    bit_idx_next    = bit_idx;
    shift_next      = shift;
    drive           = (phase == PH_LOW);
    done            = 1'b0;
    err             = 1'b0;
    rdata           = 8'd0;
    start           = 1'b0;
    tdec            = timer - us_t'(1);
    low_len         = at_least_one(regs[REG_READ_LOW]);

    case (head.kind)
      KIND_CMD: begin
        if (phase != PH_IDLE) begin
          err = 1'b1;
        end else begin
          active_cmd_next = head.cmd;
          bit_idx_next    = 3'd0;
          shift_next      = (head.cmd == REQ_WRITE) ? head.data_byte : 8'd0;
          start           = 1'b1;
          drive           = 1'b1;
        end
      end
      KIND_TICK: begin
        case (phase)
          PH_LOW: begin
            timer_next = tdec;
            if (tdec == '0) begin
              if (active_cmd == REQ_READ) begin
                if (regs[REG_READ_SAMPLE] > low_len) begin
                  phase_next = PH_GAP;
                  timer_next = regs[REG_READ_SAMPLE] - low_len;
                end else begin
                  phase_next = PH_TAIL;
                  timer_next = ReadTailUs;
                end
              end else begin
                phase_next = PH_RELEASE;
                case (active_cmd)
                  REQ_RESET: timer_next = at_least_one(regs[REG_RESET_REL]);
                  REQ_LONG:  timer_next = at_least_one(regs[REG_LONG_REL]);
                  default:   timer_next = shift[bit_idx] ? W1ReleaseUs : W0ReleaseUs;
                endcase
              end
            end
          end
          PH_GAP: begin
            timer_next = tdec;
            if (tdec == '0) begin
              phase_next = PH_TAIL;
              timer_next = ReadTailUs;
            end
          end
          PH_TAIL: begin
            // sample on the first tail tick
            if (timer == ReadTailUs) begin
              shift_next[bit_idx] = shift[bit_idx] | head.line_level;
            end
            timer_next = tdec;
            if (tdec == '0) begin
              if (bit_idx == 3'd7) begin
                phase_next = PH_IDLE;
                timer_next = '0;
                done       = 1'b1;
                rdata      = shift_next;
              end else begin
                bit_idx_next = bit_idx + 3'd1;
                start        = 1'b1;
              end
            end
          end
          PH_RELEASE: begin
            timer_next = tdec;
            if (tdec == '0) begin
              if (active_cmd == REQ_RESET || active_cmd == REQ_LONG) begin
                phase_next = PH_IDLE;
                done       = 1'b1;
              end else if (bit_idx == 3'd7) begin
                phase_next = PH_IDLE;
                timer_next = '0;
                done       = 1'b1;
              end else begin
                bit_idx_next = bit_idx + 3'd1;
                start        = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    // open the next slot with the bit it carries
    start_bit = shift_next[bit_idx_next];
    case (active_cmd_next)
      REQ_RESET: slot_len = regs[REG_RESET_LOW];
      REQ_LONG:  slot_len = regs[REG_LONG_LOW];
      REQ_WRITE: slot_len = start_bit ? regs[REG_W1_LOW] : regs[REG_W0_LOW];
      default:   slot_len = regs[REG_READ_LOW];
    endcase
    if (start) begin
      phase_next = PH_LOW;
      timer_next = at_least_one(slot_len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= RegResetVals;
    end else if (cfg_ch.valid) begin
      regs[cfg_ch.index] <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      active_cmd   <= REQ_TICK;
      timer        <= '0;
      bit_idx      <= 3'd0;
      shift        <= 8'd0;
      res_ch.valid <= 1'b0;
    end else begin
      if (pop) begin
        phase      <= phase_next;
        active_cmd <= active_cmd_next;
        timer      <= timer_next;
        bit_idx    <= bit_idx_next;
        shift      <= shift_next;
      end
      if (pop) begin
        res_ch.valid <= 1'b1;
      end else if (res_ch.ready) begin
        res_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_ch.drive_low <= drive;
      res_ch.busy_res  <= (phase_next != PH_IDLE);
      res_ch.done_res  <= done;
      res_ch.read_data <= rdata;
      res_ch.cmd_error <= err;
    end
  end

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
      res_ch.valid && res_ch.done_res |-> !res_ch.busy_res)
    else $error("done result still busy");
  a_err_busy: assert property (@(posedge clk) disable iff (rst)
      res_ch.valid && res_ch.cmd_error |-> res_ch.busy_res)
    else $error("command error while idle");
  a_data_on_done: assert property (@(posedge clk) disable iff (rst)
      res_ch.valid && !res_ch.done_res |-> res_ch.read_data == 8'd0)
    else $error("read data outside done");
  a_idle_timer: assert property (@(posedge clk) disable iff (rst)
      phase == PH_IDLE |-> timer == '0)
    else $error("timer running while idle");
`endif

endmodule

// ----- src/one_wire_master.sv -----
// Top level of the 1-Wire bus master.
// Usage:
//   req_ch carries one item per transfer: a tick (one microsecond of bus
//   time with the sampled line level) or a command (reset, long reset,
//   write byte, read byte). Each request yields exactly one result on
//   res_ch: drive level for that microsecond, busy, done, read byte and a
//   command error flag. A command that arrives while busy is dropped and
//   flagged. cfg_ch writes the eight 10-bit timing registers; write them
//   only while the master is idle and no result is pending.
// Timing:
//   A request is queued in a two-entry queue by the front end and carried
//   out by the sequencer once it is at the head and the output register is
//   free; its result is then loaded into the output register. One request
//   per cycle is sustained while res_ch does not stall.
// Reset:
//   rst (synchronous) empties the queue, returns the sequencer to idle and
//   loads the default timings (60, 50, 720, 10, 60, 5, 2, 15 us).
// Stall:
//   When res_ch stalls, the result holds and the queue fills; req_ch.ready
//   drops once both queue entries are taken.
module one_wire_master import omw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  omw_req_if.sink     req_ch,
  omw_res_if.source   res_ch,
  omw_cfg_if.sink     cfg_ch
);

  entry_t head;
  logic   head_valid;
  logic   pop;

  omw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_ch     (req_ch),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  omw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_ch     (cfg_ch),
    .res_ch     (res_ch),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

endmodule

// ----- verif/tb_one_wire_master.sv -----
// Testbench for the 1-Wire bus master: directed rows, then random traffic against a predictor.
module tb_one_wire_master;
  import omw_pkg::*;

  typedef enum logic [2:0] {
    BUS_IDLE,
    BUS_LOW,
    BUS_RELEASE,
    BUS_GAP,
    BUS_TAIL
  } bus_phase_t;

  typedef enum {
    TM_FLOOR,
    TM_ZERO,
    TM_SHORT
  } timing_profile_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       cmd_error;
  } line_result_t;

  typedef struct packed {
    logic [2:0]   req;
    logic [7:0]   data;
    logic         line;
    int           reps;
    bit           typed;
    line_result_t want;
  } dir_row_t;

  localparam logic [2:0] ReqSpareLo = 3'd5;
  localparam logic [2:0] ReqSpareHi = 3'd7;
  localparam int StallLimit = 4000;
  localparam int HoldCycles = 300;
  localparam int LogCap     = 40;

  localparam line_result_t ResQuiet  = '0;
  localparam line_result_t ResLow    = '{1'b1, 1'b1, 1'b0, 8'h00, 1'b0};
  localparam line_result_t ResLowErr = '{1'b1, 1'b1, 1'b0, 8'h00, 1'b1};
  localparam line_result_t ResDone   = '{1'b0, 1'b0, 1'b1, 8'h00, 1'b0};

  // Walked with the reset timings; tick counts cover each command exactly.
  localparam dir_row_t DirRows [10] = '{
    '{REQ_TICK,   8'h00, 1'b1, 1,   1'b1, ResQuiet},
    '{ReqSpareHi, 8'hFF, 1'b1, 1,   1'b1, ResQuiet},
    '{REQ_RESET,  8'hFF, 1'b1, 1,   1'b1, ResLow},
    '{REQ_WRITE,  8'hA5, 1'b0, 1,   1'b1, ResLowErr},
    '{REQ_READ,   8'h00, 1'b1, 1,   1'b1, ResLowErr},
    '{REQ_LONG,   8'h00, 1'b0, 1,   1'b1, ResLowErr},
    '{REQ_RESET,  8'h00, 1'b0, 1,   1'b1, ResLowErr},
    '{ReqSpareLo, 8'h00, 1'b0, 1,   1'b1, ResLow},
    '{REQ_TICK,   8'h00, 1'b0, 109, 1'b0, ResQuiet},
    '{REQ_TICK,   8'h00, 1'b1, 1,   1'b1, ResDone}
  };

  logic clk;
  logic rst;

  omw_req_if req_ch ();
  omw_res_if res_ch ();
  omw_cfg_if cfg_ch ();

  one_wire_master dut (
    .clk    (clk),
    .rst    (rst),
    .req_ch (req_ch),
    .res_ch (res_ch),
    .cfg_ch (cfg_ch)
  );

  // Predicted master state and timing registers
  us_t        timing [NumRegs];
  bus_phase_t bus_phase;
  logic [2:0] cur_cmd;
  us_t        slot_left;
  logic [2:0] bit_pos;
  logic [7:0] shifter;

  line_result_t pending_results [$];
  line_result_t seen_res;
  line_result_t due_res;
  int           mismatch_count;
  int           quiet_cycles;
  int           src_idle_pct;
  int           sink_idle_pct;
  int           hold_asks;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void open_slot();
    us_t len;
    case (cur_cmd)
      REQ_RESET: len = timing[REG_RESET_LOW];
      REQ_LONG:  len = timing[REG_LONG_LOW];
      REQ_WRITE: len = shifter[bit_pos] ? timing[REG_W1_LOW] : timing[REG_W0_LOW];
      default:   len = timing[REG_READ_LOW];
    endcase
    bus_phase = BUS_LOW;
    slot_left = (len == '0) ? us_t'(1) : len;
  endfunction

  // Returns 1 when the last bit slot of the byte has ended.
  function automatic bit next_bit();
    if (bit_pos == 3'd7) begin
      bus_phase = BUS_IDLE;
      slot_left = '0;
      return 1'b1;
    end
    bit_pos++;
    open_slot();
    return 1'b0;
  endfunction

  function automatic void close_low();
    us_t low;
    us_t rel;
    if (cur_cmd == REQ_READ) begin
      low = (timing[REG_READ_LOW] == '0) ? us_t'(1) : timing[REG_READ_LOW];
      // sample lands on the first released tick when it falls inside the low time
      if (timing[REG_READ_SAMPLE] > low) begin
        bus_phase = BUS_GAP;
        slot_left = timing[REG_READ_SAMPLE] - low;
      end else begin
        bus_phase = BUS_TAIL;
        slot_left = ReadTailUs;
      end
    end else begin
      case (cur_cmd)
        REQ_RESET: rel = (timing[REG_RESET_REL] == '0) ? us_t'(1) : timing[REG_RESET_REL];
        REQ_LONG:  rel = (timing[REG_LONG_REL] == '0) ? us_t'(1) : timing[REG_LONG_REL];
        default:   rel = shifter[bit_pos] ? W1ReleaseUs : W0ReleaseUs;
      endcase
      bus_phase = BUS_RELEASE;
      slot_left = rel;
    end
  endfunction

  function automatic line_result_t advance_bus(input logic [2:0] req, input logic [7:0] data,
                                               input logic line);
    line_result_t r;
    r = '0;
    r.drive_low = (bus_phase == BUS_LOW);
    if (req >= REQ_RESET && req <= REQ_READ) begin
      if (bus_phase != BUS_IDLE) begin
        r.cmd_error = 1'b1;
      end else begin
        cur_cmd = req;
        bit_pos = '0;
        shifter = (req == REQ_WRITE) ? data : 8'h00;
        open_slot();
        r.drive_low = 1'b1;
      end
    end else if (req == REQ_TICK && bus_phase != BUS_IDLE) begin
      case (bus_phase)
        BUS_LOW: begin
          slot_left--;
          if (slot_left == '0) close_low();
        end
        BUS_GAP: begin
          slot_left--;
          if (slot_left == '0) begin
            bus_phase = BUS_TAIL;
            slot_left = ReadTailUs;
          end
        end
        BUS_TAIL: begin
          if (slot_left == ReadTailUs) shifter[bit_pos] = shifter[bit_pos] | line;
          slot_left--;
          if (slot_left == '0 && next_bit()) begin
            r.done_res = 1'b1;
            r.read_data = shifter;
          end
        end
        default: begin
          slot_left--;
          if (slot_left == '0) begin
            if (cur_cmd == REQ_RESET || cur_cmd == REQ_LONG) begin
              bus_phase = BUS_IDLE;
              r.done_res = 1'b1;
            end else if (next_bit()) begin
              r.done_res = 1'b1;
            end
          end
        end
      endcase
    end
    r.busy_res = (bus_phase != BUS_IDLE);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatch_count++;
    // keep the log short when the block is badly off
    if (mismatch_count <= LogCap)
      $display("mismatch at %0t on %s: got %0h, expected %0h", $time, field, got, want);
  endtask

  // Enter and leave at a falling edge.
  task automatic send_item(input logic [2:0] req, input logic [7:0] data, input logic line,
                           input bit typed, input line_result_t want);
    line_result_t calc;
    while ($urandom_range(99, 0) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= req;
    req_ch.data_byte  <= data;
    req_ch.line_level <= line;
    do @(posedge clk); while (!req_ch.ready);
    calc = advance_bus(req, data, line);
    pending_results.push_back(typed ? want : calc);
    @(negedge clk);
  endtask

  task automatic write_timing(input reg_idx_t idx, input us_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    timing[idx] = val;
    @(negedge clk);
  endtask

  // Tick the bus until the command in flight ends, then drain every result.
  task automatic settle_bus();
    while (bus_phase != BUS_IDLE)
      send_item(REQ_TICK, 8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)), 1'b0,
                ResQuiet);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // Byte commands dominate the tick count, so each phase starts at most one.
  task automatic run_phase(input timing_profile_t prof, input int src_pct, input int sink_pct,
                           input int goal, input req_t byte_req, input bit with_hold);
    int  sent;
    int  pick;
    bit  byte_sent;
    us_t val;
    settle_bus();
    for (int i = 0; i < NumRegs; i++) begin
      case (prof)
        TM_FLOOR: val = us_t'(1);
        TM_ZERO:  val = '0;
        default:  val = us_t'($urandom_range(12, 0));
      endcase
      if (prof == TM_SHORT && reg_idx_t'(i) == REG_READ_SAMPLE)
        val = us_t'($urandom_range(20, 0));
      write_timing(reg_idx_t'(i), val);
    end
    cfg_ch.valid <= 1'b0;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    sent = 0;
    byte_sent = (byte_req == REQ_TICK);
    while (sent < goal || !byte_sent) begin
      pick = $urandom_range(99, 0);
      if (with_hold && sent == 20) hold_asks++;
      if (bus_phase == BUS_IDLE) begin
        if (!byte_sent && (pick < 30 || sent >= goal)) begin
          send_item(byte_req, 8'($urandom_range(255, 0)) & 8'($urandom_range(255, 0)),
                    1'($urandom_range(1, 0)), 1'b0, ResQuiet);
          byte_sent = 1'b1;
        end else if (pick < 70)
          send_item(req_t'($urandom_range(REQ_LONG, REQ_RESET)), 8'($urandom_range(255, 0)),
                    1'($urandom_range(1, 0)), 1'b0, ResQuiet);
        else if (pick < 85)
          send_item(REQ_TICK, 8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)), 1'b0,
                    ResQuiet);
        else
          send_item(3'($urandom_range(ReqSpareHi, ReqSpareLo)), 8'($urandom_range(255, 0)),
                    1'($urandom_range(1, 0)), 1'b0, ResQuiet);
      end else begin
        if (pick < 95)
          send_item(REQ_TICK, 8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)), 1'b0,
                    ResQuiet);
        else if (pick < 98)
          send_item(req_t'($urandom_range(REQ_READ, REQ_RESET)), 8'($urandom_range(255, 0)),
                    1'($urandom_range(1, 0)), 1'b0, ResQuiet);
        else
          send_item(3'($urandom_range(ReqSpareHi, ReqSpareLo)), 8'($urandom_range(255, 0)),
                    1'($urandom_range(1, 0)), 1'b0, ResQuiet);
      end
      sent++;
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int holds_done;
    holds_done = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != holds_done) begin
        holds_done = hold_asks;
        res_ch.ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
      end else begin
        res_ch.ready <= ($urandom_range(99, 0) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      seen_res = '{res_ch.drive_low, res_ch.busy_res, res_ch.done_res, res_ch.read_data,
                   res_ch.cmd_error};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer", 8'h00, 8'h00);
      end else begin
        due_res = pending_results.pop_front();
        if (seen_res.drive_low !== due_res.drive_low)
          report_mismatch("drive_low", 8'(seen_res.drive_low), 8'(due_res.drive_low));
        if (seen_res.busy_res !== due_res.busy_res)
          report_mismatch("busy_res", 8'(seen_res.busy_res), 8'(due_res.busy_res));
        if (seen_res.done_res !== due_res.done_res)
          report_mismatch("done_res", 8'(seen_res.done_res), 8'(due_res.done_res));
        if (seen_res.read_data !== due_res.read_data)
          report_mismatch("read_data", seen_res.read_data, due_res.read_data);
        if (seen_res.cmd_error !== due_res.cmd_error)
          report_mismatch("cmd_error", 8'(seen_res.cmd_error), 8'(due_res.cmd_error));
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_TICK;
    req_ch.data_byte  = 8'h00;
    req_ch.line_level = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_RESET_LOW;
    cfg_ch.data       = '0;
    src_idle_pct      = 16;
    sink_idle_pct     = 69;
    for (int i = 0; i < NumRegs; i++) timing[i] = RegResetVals[i];
    bus_phase = BUS_IDLE;
    cur_cmd   = REQ_TICK;
    slot_left = '0;
    bit_pos   = '0;
    shifter   = '0;

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < $size(DirRows); r++)
      for (int k = 0; k < DirRows[r].reps; k++)
        send_item(DirRows[r].req, DirRows[r].data, DirRows[r].line, DirRows[r].typed,
                  DirRows[r].want);

    run_phase(TM_FLOOR, 16, 69, 25, REQ_TICK,  1'b0);
    run_phase(TM_SHORT, 69, 16, 25, REQ_READ,  1'b0);
    run_phase(TM_ZERO,  0,  0,  60, REQ_WRITE, 1'b1);

    settle_bus();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
